// File: sv/paged_bitmap_slot_allocator_assert.svh
// Assertion macros for the paged bitmap slot allocator.
`ifndef PAGED_BITMAP_SLOT_ALLOCATOR_ASSERT_SVH
`define PAGED_BITMAP_SLOT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define PBSA_ASSERT_IMPL(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error("pbsa assertion failed");

// Next-cycle implication, clocked on clk_i, off during reset.
`define PBSA_ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) \
    else $error("pbsa assertion failed");

`endif

// File: sv/pbsa_pkg.sv
// Types and constants of the paged bitmap slot allocator.
package pbsa_pkg;

  localparam int unsigned SLOT_W     = 12;
  localparam int unsigned PAGE_W     = 6;
  localparam int unsigned BIT_W      = 6;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned NPAGES     = 64;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned OP_W       = 3;
  localparam int unsigned ST_W       = 3;

  localparam logic [CNT_W-1:0]  PAGE_LIMIT = 7'd64;
  localparam logic [SLOT_W-1:0] INVALID_ID = 12'd4095;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 3'd0,
    OP_OCCUPY  = 3'd1,
    OP_RELEASE = 3'd2,
    OP_QUERY   = 3'd3,
    OP_CLEAR   = 3'd4
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_NOSPACE  = 3'd1,
    ST_INVALID  = 3'd2,
    ST_CONFLICT = 3'd3,
    ST_NOTFOUND = 3'd4
  } st_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  // directory update issued by the execute step
  typedef struct packed {
    logic              clear;
    logic              cnt_en;
    logic [CNT_W-1:0]  cnt;
    logic              nf_en;
    logic              nf_val;
    logic [PAGE_W-1:0] page;
  } dir_upd_t;

  // directory status seen by the control
  typedef struct packed {
    logic [CNT_W-1:0]  cnt;
    logic              any_nf;
    logic [PAGE_W-1:0] low_nf;
    logic [NPAGES-1:0] nf;
    logic [NPAGES-1:0] fresh;
  } dir_stat_t;

  // lowest set bit; 63 when the word is zero
  function automatic logic [BIT_W-1:0] lowest_bit(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] b;
    b = BIT_W'(WORD_W - 1);
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) begin
        b = BIT_W'(i);
      end
    end
    return b;
  endfunction

endpackage

// File: sv/pbsa_if.sv
// Request and response channel interfaces of the slot allocator.
interface pbsa_req_if;
  import pbsa_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [SLOT_W-1:0] slot_id;
  modport source (output valid, opcode, slot_id, input ready);
  modport sink (input valid, opcode, slot_id, output ready);
endinterface

interface pbsa_rsp_if;
  import pbsa_pkg::*;
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [SLOT_W-1:0] result_id;
  logic [CNT_W-1:0]  pages_open;
  modport source (output valid, status, result_id, pages_open, input ready);
  modport sink (input valid, status, result_id, pages_open, output ready);
endinterface

// File: sv/pbsa_bitmap_mem.sv
// Free bitmap memory, one 64-bit word per page, registered read.
module pbsa_bitmap_mem
  import pbsa_pkg::*;
(
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [PAGE_W-1:0] waddr_i,
  input  logic [WORD_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [PAGE_W-1:0] raddr_i,
  output logic [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0] mem_q [NPAGES];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/pbsa_page_dir.sv
// Page directory: page count, not-full flags, fresh-page flags, lowest not-full search.
module pbsa_page_dir
  import pbsa_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  dir_upd_t  upd_i,
  output dir_stat_t stat_o
);

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [NPAGES-1:0] nf_q, nf_d;
  logic [NPAGES-1:0] fresh_q, fresh_d;
  logic [PAGE_W-1:0] low_nf;

  always_comb begin
    cnt_d   = cnt_q;
    nf_d    = nf_q;
    fresh_d = fresh_q;
    if (upd_i.clear) begin
      cnt_d   = '0;
      nf_d    = '0;
      fresh_d = '0;
    end else begin
      if (upd_i.cnt_en) begin
        cnt_d = upd_i.cnt;
        for (int i = 0; i < NPAGES; i++) begin
          if (CNT_W'(i) >= cnt_q && CNT_W'(i) < upd_i.cnt) begin
            nf_d[i]    = 1'b1;
            fresh_d[i] = 1'b1;
          end
        end
      end
      // a bitmap write makes the memory word current
      if (upd_i.nf_en) begin
        nf_d[upd_i.page]    = upd_i.nf_val;
        fresh_d[upd_i.page] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      nf_q    <= '0;
      fresh_q <= '0;
    end else begin
      cnt_q   <= cnt_d;
      nf_q    <= nf_d;
      fresh_q <= fresh_d;
    end
  end

  always_comb begin
    low_nf = '0;
    for (int i = NPAGES - 1; i >= 0; i--) begin
      if (nf_q[i]) begin
        low_nf = PAGE_W'(i);
      end
    end
  end

  assign stat_o.cnt    = cnt_q;
  assign stat_o.any_nf = |nf_q;
  assign stat_o.low_nf = low_nf;
  assign stat_o.nf     = nf_q;
  assign stat_o.fresh  = fresh_q;

endmodule

// File: sv/paged_bitmap_slot_allocator.sv
// Top level of the paged bitmap slot allocator.
// Flow: an accepted request registers its operands and reads one bitmap word;
// the execute step then modifies and writes back that word and loads the response
// register, waiting while that register is full. No new request is taken until then.
// A new request is taken while the previous response still waits in its register.
// Reset: all pages closed, page count zero; bitmap memory is not cleared.
module paged_bitmap_slot_allocator
  import pbsa_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  pbsa_req_if.sink   req_i,
  pbsa_rsp_if.source rsp_o
);

  `include "paged_bitmap_slot_allocator_assert.svh"

  state_e            state_q, state_d;
  logic [OP_W-1:0]   op_q;
  logic [SLOT_W-1:0] sid_q;
  logic [PAGE_W-1:0] page_q;

  logic              out_valid_q;
  st_e               status_q;
  logic [SLOT_W-1:0] rid_q;
  logic [CNT_W-1:0]  pages_q;

  dir_upd_t          upd;
  dir_stat_t         dir;

  logic              req_fire;
  logic [PAGE_W-1:0] page_sel;
  logic [WORD_W-1:0] rdata;
  logic              out_free;
  logic              out_load;

  logic [WORD_W-1:0] word;
  logic [WORD_W-1:0] w_eff;
  logic [WORD_W-1:0] wnew;
  logic [WORD_W-1:0] mask;
  logic              in_open;
  logic              nf_eff;
  logic [BIT_W-1:0]  bit_sel;
  logic [SLOT_W-1:0] new_id;
  logic              we;
  st_e               st;
  logic [SLOT_W-1:0] rid;
  logic [CNT_W-1:0]  cnt_next;

  pbsa_page_dir u_dir (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (upd),
    .stat_o (dir)
  );

  pbsa_bitmap_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (page_q),
    .wdata_i (wnew),
    .re_i    (req_fire),
    .raddr_i (page_sel),
    .rdata_o (rdata)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign out_load    = (state_q == S_EXEC) && out_free;

  always_comb begin
    if (req_i.opcode == OP_ALLOC) begin
      page_sel = dir.any_nf ? dir.low_nf : dir.cnt[PAGE_W-1:0];
    end else begin
      page_sel = req_i.slot_id[SLOT_W-1 -: PAGE_W];
    end
  end

  // execute step
  always_comb begin
    word    = dir.fresh[page_q] ? '1 : rdata;
    mask    = WORD_W'(1) << sid_q[BIT_W-1:0];
    in_open = ({1'b0, page_q} < dir.cnt);
    w_eff   = in_open ? word : '1;
    nf_eff  = in_open ? dir.nf[page_q] : 1'b1;
    bit_sel = lowest_bit(word);
    new_id  = {page_q, bit_sel};
    wnew    = word;
    we      = 1'b0;
    st      = ST_INVALID;
    rid     = sid_q;
    upd     = '0;
    upd.page = page_q;
    case (op_q)
      OP_ALLOC: begin
        rid = '0;
        if (!dir.any_nf) begin
          if (dir.cnt < PAGE_LIMIT) begin
            upd.cnt_en = 1'b1;
            upd.cnt    = dir.cnt + CNT_W'(1);
            bit_sel    = '0;
            new_id     = {page_q, bit_sel};
            word       = '1;
          end
        end
        if (!dir.any_nf && !(dir.cnt < PAGE_LIMIT)) begin
          st = ST_NOSPACE;
        end else if (new_id >= INVALID_ID) begin
          st = ST_NOSPACE;
        end else begin
          wnew       = word & ~(WORD_W'(1) << bit_sel);
          we         = 1'b1;
          upd.nf_en  = 1'b1;
          upd.nf_val = |wnew;
          st         = ST_OK;
          rid        = new_id;
        end
      end
      OP_OCCUPY: begin
        if (sid_q == INVALID_ID) begin
          st = ST_INVALID;
        end else begin
          if (!in_open) begin
            upd.cnt_en = 1'b1;
            upd.cnt    = {1'b0, page_q} + CNT_W'(1);
          end
          if (!nf_eff || (w_eff & mask) == '0) begin
            st = ST_CONFLICT;
          end else begin
            wnew       = w_eff & ~mask;
            we         = 1'b1;
            upd.nf_en  = 1'b1;
            upd.nf_val = |wnew;
            st         = ST_OK;
          end
        end
      end
      OP_RELEASE: begin
        if (sid_q == INVALID_ID || !in_open) begin
          st = ST_INVALID;
        end else begin
          wnew       = word | mask;
          we         = 1'b1;
          upd.nf_en  = 1'b1;
          upd.nf_val = 1'b1;
          st         = ST_OK;
        end
      end
      OP_QUERY: begin
        st = (!in_open || (word & mask) != '0) ? ST_NOTFOUND : ST_OK;
      end
      OP_CLEAR: begin
        upd.clear = 1'b1;
        st        = ST_OK;
      end
      default: begin
        st = ST_INVALID;
      end
    endcase
    if (!out_load) begin
      upd = '0;
      we  = 1'b0;
    end
    cnt_next = upd.clear ? '0 : (upd.cnt_en ? upd.cnt : dir.cnt);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      op_q   <= req_i.opcode;
      sid_q  <= req_i.slot_id;
      page_q <= page_sel;
    end
    if (out_load) begin
      status_q <= st;
      rid_q    <= rid;
      pages_q  <= cnt_next;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = status_q;
  assign rsp_o.result_id  = rid_q;
  assign rsp_o.pages_open = pages_q;

  `PBSA_ASSERT_NEXT(a_accept_to_exec, req_fire, state_q == S_EXEC)
  `PBSA_ASSERT_IMPL(a_no_overrun, out_valid_q && !rsp_o.ready, !out_load)
  `PBSA_ASSERT_IMPL(a_cnt_limit, 1'b1, dir.cnt <= PAGE_LIMIT)
  `PBSA_ASSERT_IMPL(a_no_write_idle, state_q == S_IDLE, !we && upd == '0)

endmodule
